[design/modexp_pkg.sv]
package modexp_pkg;
  localparam int unsigned WordBitsDefault = 64;
  localparam int unsigned FieldBits = 64;
endpackage

[design/modexp_if.sv]
interface modexp_in_if;
  logic valid;
  logic ready;
  logic [modexp_pkg::FieldBits-1:0] base_value;
  logic [modexp_pkg::FieldBits-1:0] exponent;
  modport source (output valid, base_value, exponent, input ready);
  modport sink (input valid, base_value, exponent, output ready);
endinterface

interface modexp_out_if;
  logic valid;
  logic ready;
  logic [modexp_pkg::FieldBits-1:0] power_result;
  logic error_flag;
  modport source (output valid, power_result, error_flag, input ready);
  modport sink (input valid, power_result, error_flag, output ready);
endinterface

[design/modexp_mulmod.sv]
// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// Operands must already be below the modulus; modulus must be nonzero.
module modexp_mulmod #(
  parameter int unsigned WordBits = modexp_pkg::WordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] x_i,
  input  logic [WordBits-1:0] y_i,
  input  logic [WordBits-1:0] m_i,
  output logic                done_o,
  output logic [WordBits-1:0] r_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] x_q, x_d, y_q, y_d, r_q, r_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [WordBits:0]   dbl, dbl_red, add;
  logic [WordBits-1:0] dbl_w;

  always_comb begin
    dbl     = {r_q, 1'b0};
    dbl_red = (dbl >= {1'b0, m_i}) ? dbl - {1'b0, m_i} : dbl;
    dbl_w   = dbl_red[WordBits-1:0];
    add     = {1'b0, dbl_w} + {1'b0, x_q};
    if (y_q[WordBits-1] && add >= {1'b0, m_i}) begin
      add = add - {1'b0, m_i};
    end
    x_d = x_q;
    y_d = y_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      x_d = x_i;
      y_d = y_i;
      r_d = '0;
      cnt_d = CntBits'(WordBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = y_q[WordBits-1] ? add[WordBits-1:0] : dbl_w;
      y_d = {y_q[WordBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;
endmodule

[design/modexp_reduce.sv]
// Bit-serial remainder a mod m by restoring shift-subtract, one bit per cycle.
module modexp_reduce #(
  parameter int unsigned WordBits = modexp_pkg::WordBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] a_i,
  input  logic [WordBits-1:0] m_i,
  output logic                done_o,
  output logic [WordBits-1:0] r_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] a_q, a_d, r_q, r_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [WordBits:0]   sh;

  always_comb begin
    sh = {r_q, a_q[WordBits-1]};
    a_d = a_q;
    r_d = r_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      a_d = a_i;
      r_d = '0;
      cnt_d = CntBits'(WordBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d = (sh >= {1'b0, m_i}) ? WordBits'(sh - {1'b0, m_i}) : sh[WordBits-1:0];
      a_d = {a_q[WordBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    r_q <= r_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;
endmodule

[design/modular_exponentiation_unit.sv]
// Computes base_value^exponent mod modulus by right-to-left square-and-multiply.
// One item at a time: the base is first reduced by the bit-serial reducer, then each
// of the WordBits exponent bits runs a square and a multiply on two bit-serial
// modular multipliers in parallel, the product being kept only when the bit is
// set; each bit passes through a start state (StBit) and a wait for the done
// strobe (StWait). A new input is taken only once the result has been accepted
// from the output. A zero modulus skips the reduction and multiplies and answers
// with power_result zero and error_flag set. The modulus resets to 1.
module modular_exponentiation_unit #(
  parameter int unsigned WordBits = modexp_pkg::WordBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [modexp_pkg::FieldBits-1:0]  cfg_wdata_i,
  modexp_in_if.sink                         in_if,
  modexp_out_if.source                      out_if
);
  localparam int unsigned FB = modexp_pkg::FieldBits;
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StRed  = 5'b00010,
    StBit  = 5'b00100,
    StWait = 5'b01000,
    StOut  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [WordBits-1:0] mod_q, b_q, b_d, r_q, r_d, e_q, e_d;
  logic [CntBits-1:0]  bits_q, bits_d;
  logic [FB-1:0]       res_q, res_d;
  logic                err_q, err_d;
  logic                red_start, mul_start, red_done, sq_done, mu_done;
  logic [WordBits-1:0] red_r, sq_r, mu_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= WordBits'(1);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i[WordBits-1:0];
    end
  end

  modexp_reduce #(.WordBits(WordBits)) u_red (
    .clk_i, .rst_ni, .start_i(red_start), .a_i(in_if.base_value[WordBits-1:0]),
    .m_i(mod_q), .done_o(red_done), .r_o(red_r)
  );

  modexp_mulmod #(.WordBits(WordBits)) u_sq (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(b_q), .y_i(b_q), .m_i(mod_q),
    .done_o(sq_done), .r_o(sq_r)
  );

  modexp_mulmod #(.WordBits(WordBits)) u_mu (
    .clk_i, .rst_ni, .start_i(mul_start), .x_i(r_q), .y_i(b_q), .m_i(mod_q),
    .done_o(mu_done), .r_o(mu_r)
  );

  always_comb begin
    state_d = state_q;
    b_d = b_q;
    r_d = r_q;
    e_d = e_q;
    bits_d = bits_q;
    res_d = res_q;
    err_d = err_q;
    red_start = 1'b0;
    mul_start = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (in_if.valid) begin
          e_d = in_if.exponent[WordBits-1:0];
          // One mod m is zero only when m is one.
          r_d = (mod_q == WordBits'(1)) ? '0 : WordBits'(1);
          bits_d = CntBits'(WordBits);
          if (mod_q == '0) begin
            res_d = '0;
            err_d = 1'b1;
            state_d = StOut;
          end else begin
            err_d = 1'b0;
            red_start = 1'b1;
            state_d = StRed;
          end
        end
      end
      StRed: begin
        if (red_done) begin
          b_d = red_r;
          state_d = StBit;
        end
      end
      StBit: begin
        mul_start = 1'b1;
        state_d = StWait;
      end
      StWait: begin
        if (sq_done) begin
          if (e_q[0]) begin
            r_d = mu_r;
          end
          b_d = sq_r;
          e_d = e_q >> 1;
          bits_d = bits_q - 1'b1;
          if (bits_q == CntBits'(1)) begin
            res_d = FB'(r_d);
            state_d = StOut;
          end else begin
            state_d = StBit;
          end
        end
      end
      StOut: begin
        if (out_if.ready) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      bits_q  <= '0;
    end else begin
      state_q <= state_d;
      bits_q  <= bits_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b_q   <= b_d;
    r_q   <= r_d;
    e_q   <= e_d;
    res_q <= res_d;
    err_q <= err_d;
  end

  assign in_if.ready         = (state_q == StIdle);
  assign out_if.valid        = (state_q == StOut);
  assign out_if.power_result = res_q;
  assign out_if.error_flag   = err_q;

  // The two multipliers start together and must finish together.
  a_mul_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done == mu_done) else $error("multipliers out of step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.error_flag) |-> (out_if.power_result == '0))
    else $error("error result not zero");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_start |=> (state_q == StRed)) else $error("reduction start lost");
endmodule
